// ===== src/clcd_pkg.sv =====
package clcd_pkg;

  // Default values for the top-level parameters.
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int LINE2_OFFSET_DEF = 64;

  // Pin and command constants of the display.
  localparam logic [3:0] BUS_IDLE      = 4'hF;
  localparam logic [3:0] BUS_READ      = 4'h0;
  localparam logic [3:0] INIT_NIB_8BIT = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_CURSOR    = 8'h80;

  // Configuration reset values.
  localparam logic [15:0] ENABLE_PULSE_RST = 16'd1;
  localparam logic [15:0] BUSY_SETTLE_RST  = 16'd4;
  localparam logic [15:0] BOOTUP_RST       = 16'd16000;
  localparam logic [15:0] INIT_FIRST_RST   = 16'd5000;
  localparam logic [15:0] INIT_REPEAT_RST  = 16'd64;
  localparam logic [15:0] INIT_4BIT_RST    = 16'd64;
  localparam logic [7:0]  ENTRY_MODE_RST   = 8'd6;
  localparam logic [7:0]  DISPLAY_RST      = 8'd12;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BOOT,
    PH_IPULSE,
    PH_IWAIT,
    PH_RH1,
    PH_RL1,
    PH_RH2,
    PH_RL2,
    PH_SETTLE,
    PH_WH1,
    PH_WL1,
    PH_WH2
  } phase_e;

  // Request opcodes.
  typedef enum logic [2:0] {
    OP_CMD    = 3'd0,
    OP_DATA   = 3'd1,
    OP_CURSOR = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_INIT   = 3'd4
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE_PULSE = 3'd0,
    CFG_BUSY_SETTLE  = 3'd1,
    CFG_BOOTUP       = 3'd2,
    CFG_INIT_FIRST   = 3'd3,
    CFG_INIT_REPEAT  = 3'd4,
    CFG_INIT_4BIT    = 3'd5,
    CFG_ENTRY_MODE   = 3'd6,
    CFG_DISPLAY      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] enable_pulse_ticks;
    logic [15:0] busy_settle_ticks;
    logic [15:0] bootup_ticks;
    logic [15:0] init_first_ticks;
    logic [15:0] init_repeat_ticks;
    logic [15:0] init_4bit_ticks;
    logic [7:0]  entry_mode_cmd;
    logic [7:0]  display_cmd;
  } cfg_t;

  // One input word: a single tick of the sequencer.
  typedef struct packed {
    logic       req_valid;
    logic [2:0] opcode;
    logic [7:0] req_byte;
    logic [5:0] col;
    logic       row;
    logic [3:0] pins_in;
  } item_t;

  // One result word: pin levels during that tick.
  typedef struct packed {
    logic       pin_e;
    logic       pin_rs;
    logic       pin_rw;
    logic [3:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
  } res_t;

endpackage

// ===== src/clcd_cfg.sv =====
module clcd_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output clcd_pkg::cfg_t    cfg_o
);

  clcd_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register bank with its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_pulse_ticks <= clcd_pkg::ENABLE_PULSE_RST;
      cfg_q.busy_settle_ticks  <= clcd_pkg::BUSY_SETTLE_RST;
      cfg_q.bootup_ticks       <= clcd_pkg::BOOTUP_RST;
      cfg_q.init_first_ticks   <= clcd_pkg::INIT_FIRST_RST;
      cfg_q.init_repeat_ticks  <= clcd_pkg::INIT_REPEAT_RST;
      cfg_q.init_4bit_ticks    <= clcd_pkg::INIT_4BIT_RST;
      cfg_q.entry_mode_cmd     <= clcd_pkg::ENTRY_MODE_RST;
      cfg_q.display_cmd        <= clcd_pkg::DISPLAY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        clcd_pkg::CFG_ENABLE_PULSE: cfg_q.enable_pulse_ticks <= cfg_data_i;
        clcd_pkg::CFG_BUSY_SETTLE:  cfg_q.busy_settle_ticks  <= cfg_data_i;
        clcd_pkg::CFG_BOOTUP:       cfg_q.bootup_ticks       <= cfg_data_i;
        clcd_pkg::CFG_INIT_FIRST:   cfg_q.init_first_ticks   <= cfg_data_i;
        clcd_pkg::CFG_INIT_REPEAT:  cfg_q.init_repeat_ticks  <= cfg_data_i;
        clcd_pkg::CFG_INIT_4BIT:    cfg_q.init_4bit_ticks    <= cfg_data_i;
        clcd_pkg::CFG_ENTRY_MODE:   cfg_q.entry_mode_cmd     <= cfg_data_i[7:0];
        clcd_pkg::CFG_DISPLAY:      cfg_q.display_cmd        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/clcd_seq.sv =====
module clcd_seq #(
  parameter int CountWidth = clcd_pkg::COUNT_WIDTH_DEF,
  parameter int Line2Offset = clcd_pkg::LINE2_OFFSET_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  clcd_pkg::item_t item_i,
  input  clcd_pkg::cfg_t  cfg_i,
  output clcd_pkg::res_t  res_o
);

  // Largest value the tick counter can hold.
  localparam logic [32:0] CntMax = (33'd1 << CountWidth) - 33'd1;

  typedef struct packed {
    clcd_pkg::phase_e ph;
    logic [2:0]       step;
    logic             load;
  } step_t;

  clcd_pkg::phase_e      phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [7:0]            byte_q, byte_d;
  logic                  rs_q, rs_d;
  logic                  busy_q, busy_d;
  logic [2:0]            step_q, step_d;

  step_t       tgt, nxt, fin;
  logic        go;
  logic        skip;
  logic [15:0] len;
  logic [15:0] pulse;
  logic [7:0]  line_off;
  logic [7:0]  req_sel;
  logic [3:0]  nib;

  // Saturate a loaded length to the counter width.
  function automatic logic [CountWidth-1:0] clamp_len(input logic [15:0] v);
    logic [32:0] v33;
    v33 = {17'd0, v};
    if (v33 > CntMax) begin
      return CntMax[CountWidth-1:0];
    end
    return v33[CountWidth-1:0];
  endfunction

  // Phase that follows the end of the given one, with its init step update.
  function automatic step_t after_phase(input clcd_pkg::phase_e ph, input logic [2:0] step,
                                        input logic busy);
    step_t r;
    r.ph   = clcd_pkg::PH_IDLE;
    r.step = step;
    r.load = 1'b0;
    case (ph)
      clcd_pkg::PH_BOOT:   r.ph = clcd_pkg::PH_IPULSE;
      clcd_pkg::PH_IPULSE: r.ph = clcd_pkg::PH_IWAIT;
      clcd_pkg::PH_IWAIT: begin
        r.step = step + 3'd1;
        if (r.step < 3'd4) begin
          r.ph = clcd_pkg::PH_IPULSE;
        end else begin
          r.ph   = clcd_pkg::PH_RH1;
          r.load = 1'b1;
        end
      end
      clcd_pkg::PH_RH1:    r.ph = clcd_pkg::PH_RL1;
      clcd_pkg::PH_RL1:    r.ph = clcd_pkg::PH_RH2;
      clcd_pkg::PH_RH2:    r.ph = busy ? clcd_pkg::PH_RL2 : clcd_pkg::PH_SETTLE;
      clcd_pkg::PH_RL2:    r.ph = clcd_pkg::PH_RH1;
      clcd_pkg::PH_SETTLE: r.ph = clcd_pkg::PH_WH1;
      clcd_pkg::PH_WH1:    r.ph = clcd_pkg::PH_WL1;
      clcd_pkg::PH_WL1:    r.ph = clcd_pkg::PH_WH2;
      clcd_pkg::PH_WH2: begin
        if (step >= 3'd4 && step < 3'd7) begin
          r.step = step + 3'd1;
          r.ph   = clcd_pkg::PH_RH1;
          r.load = 1'b1;
        end else begin
          r.step = 3'd0;
          r.ph   = clcd_pkg::PH_IDLE;
        end
      end
      default: r.ph = clcd_pkg::PH_IDLE;
    endcase
    return r;
  endfunction

  // Command byte for each byte step of the init sequence.
  function automatic logic [7:0] init_cmd(input logic [2:0] step, input clcd_pkg::cfg_t cfg);
    case (step)
      3'd4:    return clcd_pkg::CMD_FUNC_SET;
      3'd5:    return clcd_pkg::CMD_CLEAR;
      3'd6:    return cfg.entry_mode_cmd;
      default: return cfg.display_cmd;
    endcase
  endfunction

  // A zero pulse width behaves as one tick.
  assign pulse = (cfg_i.enable_pulse_ticks == 16'd0) ? 16'd1 : cfg_i.enable_pulse_ticks;

  // Byte a request sends.
  assign line_off = item_i.row ? 8'(Line2Offset) : 8'd0;
  always_comb begin
    case (item_i.opcode)
      clcd_pkg::OP_CURSOR: req_sel = clcd_pkg::CMD_CURSOR + line_off + {2'b00, item_i.col};
      clcd_pkg::OP_CLEAR:  req_sel = clcd_pkg::CMD_CLEAR;
      default:             req_sel = item_i.req_byte;
    endcase
  end

  // First transition of this tick: a new request or the end of the current phase.
  always_comb begin
    tgt.ph   = phase_q;
    tgt.step = step_q;
    tgt.load = 1'b0;
    go       = 1'b0;
    if (adv_i) begin
      if (phase_q == clcd_pkg::PH_IDLE) begin
        if (item_i.req_valid && item_i.opcode <= clcd_pkg::OP_INIT) begin
          go       = 1'b1;
          tgt.step = 3'd0;
          tgt.ph   = (item_i.opcode == clcd_pkg::OP_INIT) ? clcd_pkg::PH_BOOT
                                                            : clcd_pkg::PH_RH1;
        end
      end else if (count_q <= CountWidth'(1)) begin
        go  = 1'b1;
        tgt = after_phase(phase_q, step_q, busy_q);
      end
    end
  end

  // Length of the phase entered; a wait of zero ticks is passed straight through.
  always_comb begin
    case (tgt.ph)
      clcd_pkg::PH_BOOT:   len = cfg_i.bootup_ticks;
      clcd_pkg::PH_SETTLE: len = cfg_i.busy_settle_ticks;
      clcd_pkg::PH_IWAIT: begin
        if (tgt.step == 3'd0) begin
          len = cfg_i.init_first_ticks;
        end else if (tgt.step < 3'd3) begin
          len = cfg_i.init_repeat_ticks;
        end else begin
          len = cfg_i.init_4bit_ticks;
        end
      end
      default: len = pulse;
    endcase
  end

  assign skip = (len == 16'd0);
  assign nxt  = after_phase(tgt.ph, tgt.step, busy_q);

  always_comb begin
    if (skip) begin
      fin      = nxt;
      fin.load = nxt.load | tgt.load;
    end else begin
      fin = tgt;
    end
  end

  // State update.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    step_d  = step_q;
    byte_d  = byte_q;
    rs_d    = rs_q;
    busy_d  = busy_q;
    if (adv_i && phase_q != clcd_pkg::PH_IDLE && count_q > CountWidth'(1)) begin
      count_d = count_q - CountWidth'(1);
    end
    if (adv_i && phase_q == clcd_pkg::PH_RH1 && go) begin
      busy_d = item_i.pins_in[3];
    end
    if (go) begin
      phase_d = fin.ph;
      step_d  = fin.step;
      if (fin.ph == clcd_pkg::PH_IDLE) begin
        count_d = '0;
      end else begin
        count_d = clamp_len(skip ? pulse : len);
      end
      if (phase_q == clcd_pkg::PH_IDLE) begin
        if (item_i.opcode != clcd_pkg::OP_INIT) begin
          byte_d = req_sel;
          rs_d   = (item_i.opcode == clcd_pkg::OP_DATA);
        end
      end
      if (fin.load) begin
        byte_d = init_cmd(fin.step, cfg_i);
        rs_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clcd_pkg::PH_IDLE;
      count_q <= '0;
      step_q  <= 3'd0;
      byte_q  <= 8'd0;
      rs_q    <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      step_q  <= step_d;
      byte_q  <= byte_d;
      rs_q    <= rs_d;
      busy_q  <= busy_d;
    end
  end

  // Pin levels follow the state at the start of the tick.
  assign nib = (step_q < 3'd3) ? clcd_pkg::INIT_NIB_8BIT : clcd_pkg::INIT_NIB_4BIT;

  always_comb begin
    res_o.pin_e     = 1'b0;
    res_o.pin_rs    = 1'b0;
    res_o.pin_rw    = 1'b0;
    res_o.bus_out   = clcd_pkg::BUS_READ;
    res_o.bus_drive = 1'b1;
    res_o.ready_res = 1'b0;
    case (phase_q)
      clcd_pkg::PH_BOOT: res_o.bus_out = clcd_pkg::BUS_IDLE;
      clcd_pkg::PH_IPULSE: begin
        res_o.pin_e   = 1'b1;
        res_o.bus_out = nib;
      end
      clcd_pkg::PH_IWAIT: res_o.bus_out = nib;
      clcd_pkg::PH_RH1, clcd_pkg::PH_RH2: begin
        res_o.pin_e     = 1'b1;
        res_o.pin_rw    = 1'b1;
        res_o.bus_drive = 1'b0;
      end
      clcd_pkg::PH_RL1, clcd_pkg::PH_RL2, clcd_pkg::PH_SETTLE: begin
        res_o.pin_rw    = 1'b1;
        res_o.bus_drive = 1'b0;
      end
      clcd_pkg::PH_WH1: begin
        res_o.pin_e   = 1'b1;
        res_o.pin_rs  = rs_q;
        res_o.bus_out = byte_q[7:4];
      end
      clcd_pkg::PH_WL1: begin
        res_o.pin_rs  = rs_q;
        res_o.bus_out = byte_q[3:0];
      end
      clcd_pkg::PH_WH2: begin
        res_o.pin_e   = 1'b1;
        res_o.pin_rs  = rs_q;
        res_o.bus_out = byte_q[3:0];
      end
      default: begin
        res_o.pin_rs    = rs_q;
        res_o.bus_out   = clcd_pkg::BUS_IDLE;
        res_o.ready_res = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/char_lcd_4bit_bus_controller_top.sv =====
// Path: a word accepted into the input register moves on to the result register,
// which offers its result word; an output stall holds it in the input register.
// Throughput: one word per cycle while the output is not stalled; one tick per word.
// Reset: the sequencer is idle with the bus driven at 0xF, both pipeline
// registers are empty and all configuration registers hold their default values.
module char_lcd_4bit_bus_controller_top #(
  parameter int CountWidth = clcd_pkg::COUNT_WIDTH_DEF,
  parameter int Line2Offset = clcd_pkg::LINE2_OFFSET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_valid_i,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  req_byte_i,
  input  logic [5:0]  col_i,
  input  logic        row_i,
  input  logic [3:0]  pins_in_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pin_e_o,
  output logic        pin_rs_o,
  output logic        pin_rw_o,
  output logic [3:0]  bus_out_o,
  output logic        bus_drive_o,
  output logic        ready_res_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  clcd_pkg::cfg_t  cfg;
  clcd_pkg::item_t in_q;
  clcd_pkg::res_t  res_d, res_q;
  logic            in_vld_q, res_vld_q;
  logic            res_free, adv, in_acc;

  clcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline control: the input register moves on when the result register is free.
  assign res_free   = !res_vld_q || !out_stall_i;
  assign adv        = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.req_valid <= req_valid_i;
      in_q.opcode    <= opcode_i;
      in_q.req_byte  <= req_byte_i;
      in_q.col       <= col_i;
      in_q.row       <= row_i;
      in_q.pins_in   <= pins_in_i;
    end
  end

  clcd_seq #(
    .CountWidth  (CountWidth),
    .Line2Offset (Line2Offset)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign pin_e_o     = res_q.pin_e;
  assign pin_rs_o    = res_q.pin_rs;
  assign pin_rw_o    = res_q.pin_rw;
  assign bus_out_o   = res_q.bus_out;
  assign bus_drive_o = res_q.bus_drive;
  assign ready_res_o = res_q.ready_res;

endmodule
